// ===== sv/rrs_pkg.sv =====
// Shared types and constants for the round-robin scheduler.
package rrs_pkg;
  localparam int NUM_TASKS = 128;
  localparam int IDW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNTW = $clog2(NUM_TASKS + 1);

  typedef logic [IDW-1:0] id_t;

  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;
  localparam logic [1:0] ST_BLOCKED  = 2'd3;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_EXIT  = 2'd1;
  localparam logic [1:0] OP_SLEEP = 2'd2;
  localparam logic [1:0] OP_SPAWN = 2'd3;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_SLICE  = 2'd1;
  localparam logic [1:0] CFG_MAXRT  = 2'd2;

  localparam logic [31:0] RST_SLICE = 32'd5000;
  localparam logic [31:0] RST_MAXRT = 32'd5000000;

  // 7-bit view of an id for the output ports
  function automatic logic [6:0] id7(input id_t id);
    logic [IDW+6:0] w;
    w = {{7{1'b0}}, id};
    return w[6:0];
  endfunction
endpackage

// ===== sv/round_robin_scheduler_with_sleep.sv =====
// Top level: round-robin task scheduler with a sleep list, one sequencer.
//
//  channel | handshake            | payload
//  in      | start / busy         | in_op, in_amount
//  out     | out_strobe (1 cycle) | out_running_valid .. out_spawn_id
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// From accept to result: a spawn checks the slot, then ends; an ignored exit or
// sleep goes straight to S_DONE; a tick with scheduling off ends after S_HOOK;
// otherwise the sleep list is walked, then run time, slice and ready queue. Each
// sleeping task visited is a read then an update, at most NUM_TASKS visits.
// Synchronous active-low reset; after reset a clearing pass over all NUM_TASKS
// slots marks every task complete, busy stays high meanwhile.
// The receiver cannot stall: a result is shown for one cycle with out_strobe.
module round_robin_scheduler_with_sleep
  import rrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [30:0] in_amount,
  output logic        out_strobe,
  output logic        out_running_valid,
  output logic [6:0]  out_running_id,
  output logic        out_to_kernel,
  output logic        out_timed_out,
  output logic        out_spawn_ok,
  output logic [6:0]  out_spawn_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SPAWN_CHK, S_SLEEP_WR,
    S_HOOK, S_WALK_RD, S_WALK_CHK,
    S_RT_RD, S_RT_CHK, S_DEQ_RD, S_DEQ_GO, S_SLICE, S_DONE
  } state_t;

  state_t state_r;
  logic en_r;
  logic [31:0] slice_r, maxrt_r;

  // stores: single access per cycle, registered read
  logic [1:0]  tstate_m [NUM_TASKS];
  logic [31:0] rtime_m  [NUM_TASKS];
  logic [32:0] sleft_m  [NUM_TASKS];
  id_t         snext_m  [NUM_TASKS];
  id_t         ring_m   [NUM_TASKS];
  // end-of-list marks travel with sleep_next
  logic        snext_end_r [NUM_TASKS];

  logic [31:0] rd_rt_r;
  logic [32:0] rd_sl_r;
  id_t         rd_sn_r, rd_ring_r;
  logic [1:0]  rd_st_r;
  logic        rd_end_r;

  logic        sh_valid_r;
  id_t         sh_r;
  id_t         qhead_r;
  logic [CNTW-1:0] qcnt_r;
  logic        cur_valid_r;
  id_t         cur_r;
  logic [31:0] since_r;
  id_t         nid_r;

  logic [30:0] amt_r;
  logic [31:0] delta_r;
  logic        kill_r, sleep_r, kern_r, timed_r, spok_r;
  id_t         spid_r;
  // walk
  id_t         wcur_r, wprev_r;
  logic        wprev_v_r, wcur_v_r;
  logic [CNTW-1:0] wsteps_r;
  logic [2:0]  deq_why_r;  // 0 after kill, 1 after sleep, 2 slice, 3 idle
  id_t         clr_r;

  localparam logic [2:0] WHY_KILL = 3'd0, WHY_SLEEP = 3'd1, WHY_SLICE = 3'd2,
                         WHY_IDLE = 3'd3;

  logic [32:0] sl_new;
  logic [31:0] rt_new;
  id_t tail_idx;
  logic [IDW:0] tail_w;
  assign sl_new = rd_sl_r - {2'b00, delta_r[30:0]};
  assign rt_new = rd_rt_r + delta_r;
  assign tail_w = {1'b0, qhead_r} + qcnt_r[IDW:0];
  assign tail_idx = (tail_w >= (IDW+1)'(NUM_TASKS)) ?
                    IDW'(tail_w - (IDW+1)'(NUM_TASKS)) : tail_w[IDW-1:0];

  function automatic id_t inc_id(input id_t x);
    return (x == id_t'(NUM_TASKS - 1)) ? '0 : id_t'(x + 1'b1);
  endfunction

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1; slice_r <= RST_SLICE; maxrt_r <= RST_MAXRT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE: en_r <= cfg_data[0];
        CFG_SLICE:  slice_r <= cfg_data;
        CFG_MAXRT:  maxrt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; sh_valid_r <= 1'b0; qhead_r <= '0;
      qcnt_r <= '0; cur_valid_r <= 1'b0; since_r <= '0; nid_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_DONE);
      case (state_r)
        S_CLEAR: begin
          tstate_m[clr_r] <= ST_COMPLETE;
          rtime_m[clr_r] <= '0;
          clr_r <= inc_id(clr_r);
          if (clr_r == id_t'(NUM_TASKS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          amt_r <= in_amount;
          kern_r <= 1'b0; timed_r <= 1'b0; spok_r <= 1'b0; spid_r <= '0;
          kill_r <= (in_op == OP_EXIT); sleep_r <= 1'b0;
          delta_r <= (in_op == OP_TICK) ? {1'b0, in_amount} : '0;
          case (in_op)
            OP_TICK: state_r <= S_HOOK;
            OP_EXIT: state_r <= (cur_valid_r && en_r) ? S_HOOK : S_DONE;
            OP_SLEEP: state_r <= (cur_valid_r && en_r) ? S_SLEEP_WR : S_DONE;
            OP_SPAWN: begin rd_st_r <= tstate_m[nid_r]; state_r <= S_SPAWN_CHK; end
            default: state_r <= S_DONE;
          endcase
        end
        S_SPAWN_CHK: begin
          if (rd_st_r == ST_COMPLETE) begin
            spok_r <= 1'b1; spid_r <= nid_r; nid_r <= inc_id(nid_r);
            rtime_m[nid_r] <= '0; tstate_m[nid_r] <= ST_READY;
            if (qcnt_r < CNTW'(NUM_TASKS)) begin
              ring_m[tail_idx] <= nid_r; qcnt_r <= qcnt_r + 1'b1;
            end
          end
          state_r <= S_DONE;
        end
        S_SLEEP_WR: begin
          // push on the list head; the end mark is set when the old list was empty
          sleft_m[cur_r] <= {2'b00, amt_r};
          snext_m[cur_r] <= sh_r;
          sh_r <= cur_r; sh_valid_r <= 1'b1;
          snext_end_r[cur_r] <= !sh_valid_r;
          sleep_r <= 1'b1;
          state_r <= S_HOOK;
        end
        S_HOOK: begin
          since_r <= since_r + delta_r;
          if (!en_r) state_r <= S_DONE;
          else begin
            wcur_r <= sh_r; wcur_v_r <= sh_valid_r; wprev_v_r <= 1'b0;
            wsteps_r <= '0;
            state_r <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          if (!wcur_v_r || wsteps_r == CNTW'(NUM_TASKS)) state_r <= S_RT_RD;
          else begin
            rd_sl_r <= sleft_m[wcur_r]; rd_sn_r <= snext_m[wcur_r];
            rd_end_r <= snext_end_r[wcur_r];
            wsteps_r <= wsteps_r + 1'b1;
            state_r <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          sleft_m[wcur_r] <= sl_new;
          if (sl_new[32] || sl_new == '0) begin
            if (!wprev_v_r) begin sh_r <= rd_sn_r; sh_valid_r <= !rd_end_r; end
            else begin
              snext_m[wprev_r] <= rd_sn_r; snext_end_r[wprev_r] <= rd_end_r;
            end
            tstate_m[wcur_r] <= ST_READY;
            if (qcnt_r < CNTW'(NUM_TASKS)) begin
              ring_m[tail_idx] <= wcur_r; qcnt_r <= qcnt_r + 1'b1;
            end
          end else begin
            wprev_r <= wcur_r; wprev_v_r <= 1'b1;
          end
          wcur_r <= rd_sn_r; wcur_v_r <= !rd_end_r;
          state_r <= S_WALK_RD;
        end
        S_RT_RD: begin
          if (!cur_valid_r) begin
            deq_why_r <= WHY_IDLE;
            state_r <= (qcnt_r != '0) ? S_DEQ_RD : S_DONE;
          end else begin
            rd_rt_r <= rtime_m[cur_r]; state_r <= S_RT_CHK;
          end
        end
        S_RT_CHK: begin
          if (kill_r || rt_new > maxrt_r) begin
            if (rt_new > maxrt_r) timed_r <= 1'b1;
            sleep_r <= 1'b0; since_r <= '0;
            tstate_m[cur_r] <= ST_COMPLETE; rtime_m[cur_r] <= '0;
            deq_why_r <= WHY_KILL; cur_valid_r <= 1'b0;
            state_r <= S_DEQ_RD;
          end else if (sleep_r) begin
            rtime_m[cur_r] <= rt_new;
            since_r <= '0; tstate_m[cur_r] <= ST_BLOCKED;
            deq_why_r <= WHY_SLEEP; cur_valid_r <= 1'b0;
            state_r <= S_DEQ_RD;
          end else begin
            rtime_m[cur_r] <= rt_new;
            state_r <= S_SLICE;
          end
        end
        S_SLICE: begin
          if (cur_valid_r && since_r > slice_r) begin
            since_r <= '0; tstate_m[cur_r] <= ST_READY;
            if (qcnt_r < CNTW'(NUM_TASKS)) begin
              ring_m[tail_idx] <= cur_r; qcnt_r <= qcnt_r + 1'b1;
            end
            cur_valid_r <= 1'b0; deq_why_r <= WHY_SLICE;
            state_r <= S_DEQ_RD;
          end else state_r <= S_DONE;
        end
        S_DEQ_RD: begin
          if (qcnt_r == '0) begin
            if (deq_why_r != WHY_IDLE) kern_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            rd_ring_r <= ring_m[qhead_r];
            qhead_r <= inc_id(qhead_r); qcnt_r <= qcnt_r - 1'b1;
            state_r <= S_DEQ_GO;
          end
        end
        S_DEQ_GO: begin
          tstate_m[rd_ring_r] <= ST_RUNNING;
          cur_r <= rd_ring_r; cur_valid_r <= 1'b1;
          state_r <= (deq_why_r == WHY_IDLE || deq_why_r == WHY_SLICE) ?
                     S_DONE : S_SLICE;
        end
        S_DONE: begin
          out_running_valid <= cur_valid_r;
          out_running_id <= cur_valid_r ? id7(cur_r) : 7'd0;
          out_to_kernel <= kern_r;
          out_timed_out <= timed_r;
          out_spawn_ok <= spok_r;
          out_spawn_id <= spok_r ? id7(spid_r) : 7'd0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_kernel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && kern_r) |-> !cur_valid_r)
    else $error("kernel return with a task running");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= CNTW'(NUM_TASKS))
    else $error("ready queue overflow");
  a_spawn_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_spawn_ok) |-> !(out_to_kernel || out_timed_out))
    else $error("spawn result mixed with dispatch flags");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");
endmodule
